// ----- rtl/ttcd_pkg.sv -----
// shared types, constants and width helpers for the time to clock digits block
// no dependencies
`default_nettype none

package ttcd_pkg;

	localparam int TIME_W  = 32;
	localparam int FMT_W   = 3;
	localparam int DIGIT_W = 4;
	localparam int COUNT_W = 3;

	// display formats
	localparam logic [FMT_W-1:0] FMT_TRAD24 = 3'd0;
	localparam logic [FMT_W-1:0] FMT_TRAD12 = 3'd1;
	localparam logic [FMT_W-1:0] FMT_DIUR5  = 3'd2;
	localparam logic [FMT_W-1:0] FMT_SEMI   = 3'd3;
	localparam logic [FMT_W-1:0] FMT_DIUR4  = 3'd4;

	// valid digit counts
	localparam logic [COUNT_W-1:0] COUNT_NONE = 3'd0;
	localparam logic [COUNT_W-1:0] COUNT_FOUR = 3'd4;
	localparam logic [COUNT_W-1:0] COUNT_FIVE = 3'd5;
	localparam logic [COUNT_W-1:0] COUNT_SIX  = 3'd6;

	// divisors applied to the millisecond count
	localparam int DIV_SEC    = 1000;
	localparam int DIV_MIN    = 60000;
	localparam int DIV_HOUR   = 3600000;
	localparam int DIV_DIUR_2 = DIV_MIN * 10;
	localparam int DIV_DIUR_3 = DIV_SEC * 50;
	localparam int DIV_DIUR_4 = 4167;
	localparam int DIV_DIUR_5 = 347;
	localparam int DIV_SEMI_3 = DIV_MIN * 5;
	localparam int DIV_SEMI_4 = DIV_SEC * 25;
	localparam int DIV_SEMI_5 = 2083;

	localparam int MOD_HOUR  = 24;
	localparam int MOD_SIXTY = 60;
	localparam int MOD_DOZEN = 12;

	// width that holds floor(x / d) for any n-bit x
	function automatic int quot_w(int n, int d);
		return n - $clog2(d) + 1;
	endfunction

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	typedef struct packed {
		logic [4:0] hr;
		logic [5:0] minute;
		logic [5:0] sec;
		logic [3:0] diur_2;
		logic [3:0] diur_3;
		logic [3:0] diur_4;
		logic [3:0] diur_5;
		logic [3:0] semi_3;
		logic [3:0] semi_4;
		logic [3:0] semi_5;
	} count_rem_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] d1;
		logic [DIGIT_W-1:0] d2;
		logic [DIGIT_W-1:0] d3;
		logic [DIGIT_W-1:0] d4;
		logic [DIGIT_W-1:0] d5;
		logic [DIGIT_W-1:0] d6;
		logic [COUNT_W-1:0] count;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/ttcd_recip_div.sv -----
// unsigned divide by a constant through a reciprocal multiply
// depends on ttcd_pkg for the quotient width helper
`default_nettype none

module ttcd_recip_div #(
	parameter int N = 32,
	parameter int D = 1000
) (
	input  wire logic [N-1:0]                          x,
	output logic      [ttcd_pkg::quot_w(N, D)-1:0]     q
);

	localparam int L     = $clog2(D);
	localparam int SHIFT = N + L;
	localparam int QW    = ttcd_pkg::quot_w(N, D);
	localparam int PW    = 2 * N + 1;
	// ceil(2^(N+L) / D) is exact for every N-bit dividend and fits in N+1 bits
	localparam logic [63:0] MAGIC = ((64'd1 << SHIFT) + 64'(D) - 64'd1) / 64'(D);

	logic [PW-1:0] prod;

	assign prod = PW'(x) * PW'(MAGIC[N:0]);
	assign q    = prod[SHIFT +: QW];

endmodule

`default_nettype wire

// ----- rtl/ttcd_mod_lane.sv -----
// two stage remainder by a constant: reciprocal quotient, then subtract back
// depends on ttcd_pkg and ttcd_recip_div
`default_nettype none

module ttcd_mod_lane #(
	parameter int N = 17,
	parameter int D = 12
) (
	input  wire logic                 clk,
	input  wire logic                 en_s3,
	input  wire logic                 en_s4,
	input  wire logic [N-1:0]         x,
	output logic      [$clog2(D)-1:0] r
);

	localparam int QW = ttcd_pkg::quot_w(N, D);
	localparam int RW = $clog2(D);

	logic [QW-1:0] q;
	logic [N-1:0]  x_s3;
	logic [QW-1:0] q_s3;
	logic [RW-1:0] r_s4;

	ttcd_recip_div #(.N(N), .D(D)) u_div (
		.x (x),
		.q (q)
	);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			x_s3 <= x;
			q_s3 <= q;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			r_s4 <= RW'(x_s3 - N'(q_s3) * N'(D));
		end
	end

	assign r = r_s4;

endmodule

`default_nettype wire

// ----- rtl/ttcd_count_split.sv -----
// splits the millisecond count into hour, minute, second and dozenal remainders
// depends on ttcd_pkg, ttcd_recip_div and ttcd_mod_lane
`default_nettype none

module ttcd_count_split (
	input  wire logic                         clk,
	input  wire ttcd_pkg::pipe_en_t           en,
	input  wire logic [ttcd_pkg::TIME_W-1:0]  time_ms,
	output ttcd_pkg::count_rem_t              rem
);

	localparam int TW    = ttcd_pkg::TIME_W;
	localparam int W_HR  = ttcd_pkg::quot_w(TW, ttcd_pkg::DIV_HOUR);
	localparam int W_MIN = ttcd_pkg::quot_w(TW, ttcd_pkg::DIV_MIN);
	localparam int W_SEC = ttcd_pkg::quot_w(TW, ttcd_pkg::DIV_SEC);
	localparam int W_D2  = ttcd_pkg::quot_w(TW, ttcd_pkg::DIV_DIUR_2);
	localparam int W_D3  = ttcd_pkg::quot_w(TW, ttcd_pkg::DIV_DIUR_3);
	localparam int W_D4  = ttcd_pkg::quot_w(TW, ttcd_pkg::DIV_DIUR_4);
	localparam int W_D5  = ttcd_pkg::quot_w(TW, ttcd_pkg::DIV_DIUR_5);
	localparam int W_S3  = ttcd_pkg::quot_w(TW, ttcd_pkg::DIV_SEMI_3);
	localparam int W_S4  = ttcd_pkg::quot_w(TW, ttcd_pkg::DIV_SEMI_4);
	localparam int W_S5  = ttcd_pkg::quot_w(TW, ttcd_pkg::DIV_SEMI_5);

	logic [TW-1:0] t_s1;

	logic [W_HR-1:0]  hr_q;
	logic [W_MIN-1:0] min_q;
	logic [W_SEC-1:0] sec_q;
	logic [W_D2-1:0]  d2_q;
	logic [W_D3-1:0]  d3_q;
	logic [W_D4-1:0]  d4_q;
	logic [W_D5-1:0]  d5_q;
	logic [W_S3-1:0]  s3_q;
	logic [W_S4-1:0]  s4_q;
	logic [W_S5-1:0]  s5_q;

	logic [W_HR-1:0]  hr_s2;
	logic [W_MIN-1:0] min_s2;
	logic [W_SEC-1:0] sec_s2;
	logic [W_D2-1:0]  d2_s2;
	logic [W_D3-1:0]  d3_s2;
	logic [W_D4-1:0]  d4_s2;
	logic [W_D5-1:0]  d5_s2;
	logic [W_S3-1:0]  s3_s2;
	logic [W_S4-1:0]  s4_s2;
	logic [W_S5-1:0]  s5_s2;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			t_s1 <= time_ms;
		end
	end

	// nested truncating divides collapse into one divide by the product
	ttcd_recip_div #(.N(TW), .D(ttcd_pkg::DIV_HOUR))   u_div_hr  (.x(t_s1), .q(hr_q));
	ttcd_recip_div #(.N(TW), .D(ttcd_pkg::DIV_MIN))    u_div_min (.x(t_s1), .q(min_q));
	ttcd_recip_div #(.N(TW), .D(ttcd_pkg::DIV_SEC))    u_div_sec (.x(t_s1), .q(sec_q));
	ttcd_recip_div #(.N(TW), .D(ttcd_pkg::DIV_DIUR_2)) u_div_d2  (.x(t_s1), .q(d2_q));
	ttcd_recip_div #(.N(TW), .D(ttcd_pkg::DIV_DIUR_3)) u_div_d3  (.x(t_s1), .q(d3_q));
	ttcd_recip_div #(.N(TW), .D(ttcd_pkg::DIV_DIUR_4)) u_div_d4  (.x(t_s1), .q(d4_q));
	ttcd_recip_div #(.N(TW), .D(ttcd_pkg::DIV_DIUR_5)) u_div_d5  (.x(t_s1), .q(d5_q));
	ttcd_recip_div #(.N(TW), .D(ttcd_pkg::DIV_SEMI_3)) u_div_s3  (.x(t_s1), .q(s3_q));
	ttcd_recip_div #(.N(TW), .D(ttcd_pkg::DIV_SEMI_4)) u_div_s4  (.x(t_s1), .q(s4_q));
	ttcd_recip_div #(.N(TW), .D(ttcd_pkg::DIV_SEMI_5)) u_div_s5  (.x(t_s1), .q(s5_q));

	always_ff @(posedge clk) begin
		if (en.s2) begin
			hr_s2  <= hr_q;
			min_s2 <= min_q;
			sec_s2 <= sec_q;
			d2_s2  <= d2_q;
			d3_s2  <= d3_q;
			d4_s2  <= d4_q;
			d5_s2  <= d5_q;
			s3_s2  <= s3_q;
			s4_s2  <= s4_q;
			s5_s2  <= s5_q;
		end
	end

	ttcd_mod_lane #(.N(W_HR), .D(ttcd_pkg::MOD_HOUR)) u_mod_hr (
		.clk(clk), .en_s3(en.s3), .en_s4(en.s4), .x(hr_s2), .r(rem.hr)
	);
	ttcd_mod_lane #(.N(W_MIN), .D(ttcd_pkg::MOD_SIXTY)) u_mod_min (
		.clk(clk), .en_s3(en.s3), .en_s4(en.s4), .x(min_s2), .r(rem.minute)
	);
	ttcd_mod_lane #(.N(W_SEC), .D(ttcd_pkg::MOD_SIXTY)) u_mod_sec (
		.clk(clk), .en_s3(en.s3), .en_s4(en.s4), .x(sec_s2), .r(rem.sec)
	);
	ttcd_mod_lane #(.N(W_D2), .D(ttcd_pkg::MOD_DOZEN)) u_mod_d2 (
		.clk(clk), .en_s3(en.s3), .en_s4(en.s4), .x(d2_s2), .r(rem.diur_2)
	);
	ttcd_mod_lane #(.N(W_D3), .D(ttcd_pkg::MOD_DOZEN)) u_mod_d3 (
		.clk(clk), .en_s3(en.s3), .en_s4(en.s4), .x(d3_s2), .r(rem.diur_3)
	);
	ttcd_mod_lane #(.N(W_D4), .D(ttcd_pkg::MOD_DOZEN)) u_mod_d4 (
		.clk(clk), .en_s3(en.s3), .en_s4(en.s4), .x(d4_s2), .r(rem.diur_4)
	);
	ttcd_mod_lane #(.N(W_D5), .D(ttcd_pkg::MOD_DOZEN)) u_mod_d5 (
		.clk(clk), .en_s3(en.s3), .en_s4(en.s4), .x(d5_s2), .r(rem.diur_5)
	);
	ttcd_mod_lane #(.N(W_S3), .D(ttcd_pkg::MOD_DOZEN)) u_mod_s3 (
		.clk(clk), .en_s3(en.s3), .en_s4(en.s4), .x(s3_s2), .r(rem.semi_3)
	);
	ttcd_mod_lane #(.N(W_S4), .D(ttcd_pkg::MOD_DOZEN)) u_mod_s4 (
		.clk(clk), .en_s3(en.s3), .en_s4(en.s4), .x(s4_s2), .r(rem.semi_4)
	);
	ttcd_mod_lane #(.N(W_S5), .D(ttcd_pkg::MOD_DOZEN)) u_mod_s5 (
		.clk(clk), .en_s3(en.s3), .en_s4(en.s4), .x(s5_s2), .r(rem.semi_5)
	);

endmodule

`default_nettype wire

// ----- rtl/ttcd_digit_fmt.sv -----
// picks and formats the displayed digits for the selected format, output register
// depends on ttcd_pkg
`default_nettype none

module ttcd_digit_fmt (
	input  wire logic                        clk,
	input  wire ttcd_pkg::pipe_en_t          en,
	input  wire logic [ttcd_pkg::FMT_W-1:0]  clock_fmt,
	input  wire ttcd_pkg::count_rem_t        rem,
	output ttcd_pkg::result_t                res
);

	localparam int DW = ttcd_pkg::DIGIT_W;

	ttcd_pkg::result_t res_d;
	ttcd_pkg::result_t res_s5;
	logic [4:0]        hr_dec;
	logic              pm;

	// tens digit of a value below 60 by parallel compares
	function automatic logic [DW-1:0] tens_of(logic [5:0] v);
		logic [DW-1:0] t;
		t = '0;
		for (int k = 1; k < 6; k++) begin
			if (v >= 6'(10 * k)) t = DW'(k);
		end
		return t;
	endfunction

	function automatic logic [DW-1:0] units_of(logic [5:0] v);
		logic [DW-1:0] t;
		t = tens_of(v);
		return DW'(v - 6'(t) * 6'd10);
	endfunction

	assign pm = (rem.hr >= 5'd12);

	always_comb begin
		// 12 hour clock keeps 0 and 12 as they are
		if (clock_fmt == ttcd_pkg::FMT_TRAD12 && rem.hr > 5'd12) begin
			hr_dec = rem.hr - 5'd12;
		end else begin
			hr_dec = rem.hr;
		end
	end

	always_comb begin
		res_d = '0;
		case (clock_fmt)
			ttcd_pkg::FMT_TRAD24, ttcd_pkg::FMT_TRAD12: begin
				res_d.d1    = tens_of(6'(hr_dec));
				res_d.d2    = units_of(6'(hr_dec));
				res_d.d3    = tens_of(rem.minute);
				res_d.d4    = units_of(rem.minute);
				res_d.d5    = tens_of(rem.sec);
				res_d.d6    = units_of(rem.sec);
				res_d.count = ttcd_pkg::COUNT_SIX;
			end
			ttcd_pkg::FMT_DIUR5: begin
				res_d.d1    = DW'(rem.hr >> 1);
				res_d.d2    = rem.diur_2;
				res_d.d3    = rem.diur_3;
				res_d.d4    = rem.diur_4;
				res_d.d5    = rem.diur_5;
				res_d.count = ttcd_pkg::COUNT_FIVE;
			end
			ttcd_pkg::FMT_DIUR4: begin
				res_d.d1    = DW'(rem.hr >> 1);
				res_d.d2    = rem.diur_2;
				res_d.d3    = rem.diur_3;
				res_d.d4    = rem.diur_4;
				res_d.count = ttcd_pkg::COUNT_FOUR;
			end
			ttcd_pkg::FMT_SEMI: begin
				res_d.d1    = DW'(pm);
				res_d.d2    = pm ? DW'(rem.hr - 5'd12) : DW'(rem.hr);
				res_d.d3    = rem.semi_3;
				res_d.d4    = rem.semi_4;
				res_d.d5    = rem.semi_5;
				res_d.count = ttcd_pkg::COUNT_FIVE;
			end
			default: begin
				res_d.count = ttcd_pkg::COUNT_NONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			res_s5 <= res_d;
		end
	end

	assign res = res_s5;

endmodule

`default_nettype wire

// ----- rtl/time_to_clock_digits.sv -----
// top level: converts a millisecond time of day into clock digits
// depends on ttcd_pkg, ttcd_count_split and ttcd_digit_fmt
//
// Input channel: time_ms with in_valid; a request is taken at a rising edge
// where in_valid is high and in_stall is low. Output channel: digit_1..digit_6
// and digit_count with out_valid, taken where out_valid is high and out_stall
// is low. One result per request, in order.
// Configuration: cfg_wr_en writes cfg_wr_data into the format register; change
// it only while no request is in flight.
// Pipeline: a result shows on out_valid after its request has gone through five
// registered stages (input, reciprocal multiply, second reciprocal multiply,
// remainder subtract, digit select).
// Throughput: one request per cycle while out_stall is low; each stage holds
// one request, and the widest reciprocal multipliers are 32 by 33 bits.
// Reset: arst_n clears all stage valids and sets the format to 24-hour.
// Stall: a stalled result holds on the outputs; stages behind it keep
// filling bubbles, and in_stall rises only once every stage is occupied.
`default_nettype none

module time_to_clock_digits (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [ttcd_pkg::FMT_W-1:0]    cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [ttcd_pkg::TIME_W-1:0]   time_ms,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [ttcd_pkg::DIGIT_W-1:0]  digit_1,
	output logic      [ttcd_pkg::DIGIT_W-1:0]  digit_2,
	output logic      [ttcd_pkg::DIGIT_W-1:0]  digit_3,
	output logic      [ttcd_pkg::DIGIT_W-1:0]  digit_4,
	output logic      [ttcd_pkg::DIGIT_W-1:0]  digit_5,
	output logic      [ttcd_pkg::DIGIT_W-1:0]  digit_6,
	output logic      [ttcd_pkg::COUNT_W-1:0]  digit_count
);

	logic [ttcd_pkg::FMT_W-1:0] clock_fmt_q;
	logic                       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	ttcd_pkg::pipe_en_t         en;
	ttcd_pkg::count_rem_t       rem;
	ttcd_pkg::result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_fmt_q <= ttcd_pkg::FMT_TRAD24;
		end else if (cfg_wr_en) begin
			clock_fmt_q <= cfg_wr_data;
		end
	end

	// a stage loads when it is empty or its content moves on
	always_comb begin
		en.s5 = !vld_s5 || !out_stall;
		en.s4 = !vld_s4 || en.s5;
		en.s3 = !vld_s3 || en.s4;
		en.s2 = !vld_s2 || en.s3;
		en.s1 = !vld_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= in_valid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
			if (en.s5) vld_s5 <= vld_s4;
		end
	end

	ttcd_count_split u_split (
		.clk     (clk),
		.en      (en),
		.time_ms (time_ms),
		.rem     (rem)
	);

	ttcd_digit_fmt u_fmt (
		.clk       (clk),
		.en        (en),
		.clock_fmt (clock_fmt_q),
		.rem       (rem),
		.res       (res)
	);

	assign in_stall    = !en.s1;
	assign out_valid   = vld_s5;
	assign digit_1     = res.d1;
	assign digit_2     = res.d2;
	assign digit_3     = res.d3;
	assign digit_4     = res.d4;
	assign digit_5     = res.d5;
	assign digit_6     = res.d6;
	assign digit_count = res.count;

endmodule

`default_nettype wire

// ----- rtl/ttcd_checker.sv -----
// port level checks for time_to_clock_digits, bound to the top level
// depends on ttcd_pkg
`default_nettype none

module ttcd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [ttcd_pkg::DIGIT_W-1:0]  digit_1,
	input wire logic [ttcd_pkg::DIGIT_W-1:0]  digit_2,
	input wire logic [ttcd_pkg::DIGIT_W-1:0]  digit_3,
	input wire logic [ttcd_pkg::DIGIT_W-1:0]  digit_4,
	input wire logic [ttcd_pkg::DIGIT_W-1:0]  digit_5,
	input wire logic [ttcd_pkg::DIGIT_W-1:0]  digit_6,
	input wire logic [ttcd_pkg::COUNT_W-1:0]  digit_count
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digit_1) && $stable(digit_2)
			&& $stable(digit_3) && $stable(digit_4) && $stable(digit_5)
			&& $stable(digit_6) && $stable(digit_count))
		else $error("stalled result changed");

	// an empty output stage lets the whole pipeline move
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit_count == ttcd_pkg::COUNT_SIX || digit_count == ttcd_pkg::COUNT_FIVE
			|| digit_count == ttcd_pkg::COUNT_FOUR || digit_count == ttcd_pkg::COUNT_NONE)
		else $error("illegal digit count");

	// digit 6 is blank unless six digits show, digit 5 too when only four show
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_count != ttcd_pkg::COUNT_SIX |-> digit_6 == '0
			&& (digit_count != ttcd_pkg::COUNT_FOUR || digit_5 == '0))
		else $error("unused digit not zero");

	a_decimal_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_count == ttcd_pkg::COUNT_SIX |-> digit_1 <= 4'd2
			&& digit_3 <= 4'd5 && digit_5 <= 4'd5 && digit_2 <= 4'd9
			&& digit_4 <= 4'd9 && digit_6 <= 4'd9)
		else $error("decimal digit out of range");

endmodule

bind time_to_clock_digits ttcd_checker u_ttcd_checker (.*);

`default_nettype wire
